// ----- sv/hsl_pkg.sv -----
`timescale 1ns / 1ps

package hsl_pkg;

  typedef struct packed {
    logic [8:0] hue_degrees;
    logic [7:0] saturation;
    logic [7:0] lightness;
  } hsl_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_out_t;

  // hue geometry in whole degrees
  localparam int unsigned HUE_WRAP        = 360;
  localparam int unsigned HUE_THIRD       = 120;
  localparam int unsigned HUE_TWO_THIRDS  = 240;
  localparam int unsigned RAMP_RISE_END   = 60;
  localparam int unsigned RAMP_FALL_START = 180;
  localparam int unsigned RAMP_FALL_END   = 240;
  localparam int unsigned RAMP_SPAN       = 60;

  localparam int unsigned CHAN_MAX    = 255;
  localparam int unsigned NUM_CHAN    = 3;
  localparam int unsigned CHAN_RED    = 0;
  localparam int unsigned CHAN_GREEN  = 1;
  localparam int unsigned CHAN_BLUE   = 2;

  // floor(x / 60) for x below 2^14: estimate by reciprocal, then one fix-up
  localparam int unsigned SCALED_W    = 14;
  localparam int unsigned DIV60_MUL   = 1092;
  localparam int unsigned DIV60_MUL_W = 11;
  localparam int unsigned DIV60_SHIFT = 16;

  typedef logic [5:0] ramp_pos_t;

  typedef struct packed {
    logic             zero_sat;
    logic [7:0]       lightness;
    ramp_pos_t [2:0]  k;
  } hsl_side_t;

  // hue plus offset, wrapped into 0..359 (hue already below 360)
  function automatic logic [8:0] hue_shift(input logic [8:0] hue, input logic [8:0] offs);
    logic [9:0] sum;
    sum = {1'b0, hue} + {1'b0, offs};
    if (sum >= 10'(HUE_WRAP)) begin
      sum = sum - 10'(HUE_WRAP);
    end
    return sum[8:0];
  endfunction

  // position on the piecewise-linear ramp, 0..60
  function automatic ramp_pos_t ramp_pos(input logic [8:0] deg);
    logic [8:0] fall;
    ramp_pos_t  k;
    fall = 9'(RAMP_FALL_END) - deg;
    if (deg < 9'(RAMP_RISE_END)) begin
      k = deg[5:0];
    end else if (deg < 9'(RAMP_FALL_START)) begin
      k = 6'(RAMP_SPAN);
    end else if (deg < 9'(RAMP_FALL_END)) begin
      k = fall[5:0];
    end else begin
      k = '0;
    end
    return k;
  endfunction

endpackage

// ----- sv/hsl_norm.sv -----
`timescale 1ns / 1ps

// scales lightness and saturation to fixed point (x * 2^F / 255, rounded)
// and works out the ramp positions of the three channels
module hsl_norm #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_in,
  input  hsl_pkg::hsl_in_t     data_in,
  output logic                 valid_out,
  output logic [FRAC_BITS:0]   lq_out,
  output logic [FRAC_BITS:0]   sq_out,
  output hsl_pkg::hsl_side_t   side_out
);

  localparam int unsigned XW  = FRAC_BITS + 8;
  localparam int unsigned QW  = FRAC_BITS + 1;
  localparam int unsigned DSH = FRAC_BITS + 9;
  localparam int unsigned RW  = FRAC_BITS + 3;
  localparam int unsigned PW  = XW + RW;
  localparam logic [63:0] RECIP_FULL = (64'd1 << DSH) / 64'd255;
  localparam logic [RW-1:0] RECIP = RECIP_FULL[RW-1:0];

  logic            valid1_r;
  logic [PW-1:0]   prod_l_r, prod_s_r;
  logic [8:0]      hue1_r;
  logic [7:0]      l1_r, s1_r;

  logic            valid2_r;
  logic [QW-1:0]   lq2_r, sq2_r;
  hsl_pkg::hsl_side_t side2_r;

  logic [XW-1:0]   x_l, x_s;
  logic [8:0]      hue_red;
  logic [QW-1:0]   lq_nxt, sq_nxt;
  hsl_pkg::hsl_side_t side_nxt;

  // adding 127 before the divide only fills the low fraction bits
  assign x_l = {data_in.lightness, FRAC_BITS'(127)};
  assign x_s = {data_in.saturation, FRAC_BITS'(127)};

  always_comb begin
    hue_red = data_in.hue_degrees;
    if (data_in.hue_degrees >= 9'(hsl_pkg::HUE_WRAP)) begin
      hue_red = data_in.hue_degrees - 9'(hsl_pkg::HUE_WRAP);
    end
  end

  // estimate is the quotient or one below it; one compare fixes it
  function automatic logic [QW-1:0] div_fix(input logic [PW-1:0] prod,
                                            input logic [7:0] raw);
    logic [QW-1:0] qe;
    logic [XW:0]   x, qm, rem;
    qe  = prod[DSH +: QW];
    x   = {1'b0, raw, FRAC_BITS'(127)};
    qm  = {qe, 8'b0} - (XW+1)'(qe);
    rem = x - qm;
    if (rem >= (XW+1)'(hsl_pkg::CHAN_MAX)) begin
      qe = qe + QW'(1);
    end
    return qe;
  endfunction

  always_comb begin
    lq_nxt = div_fix(prod_l_r, l1_r);
    sq_nxt = div_fix(prod_s_r, s1_r);
    side_nxt.zero_sat  = (s1_r == 8'd0);
    side_nxt.lightness = l1_r;
    side_nxt.k[hsl_pkg::CHAN_RED] =
      hsl_pkg::ramp_pos(hsl_pkg::hue_shift(hue1_r, 9'(hsl_pkg::HUE_THIRD)));
    side_nxt.k[hsl_pkg::CHAN_GREEN] = hsl_pkg::ramp_pos(hue1_r);
    side_nxt.k[hsl_pkg::CHAN_BLUE] =
      hsl_pkg::ramp_pos(hsl_pkg::hue_shift(hue1_r, 9'(hsl_pkg::HUE_TWO_THIRDS)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else if (en) begin
      valid1_r <= valid_in;
      valid2_r <= valid1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_l_r <= PW'(x_l) * PW'(RECIP);
      prod_s_r <= PW'(x_s) * PW'(RECIP);
      hue1_r   <= hue_red;
      l1_r     <= data_in.lightness;
      s1_r     <= data_in.saturation;
      lq2_r    <= lq_nxt;
      sq2_r    <= sq_nxt;
      side2_r  <= side_nxt;
    end
  end

  assign valid_out = valid2_r;
  assign lq_out    = lq2_r;
  assign sq_out    = sq2_r;
  assign side_out  = side2_r;

endmodule

// ----- sv/hsl_levels.sv -----
`timescale 1ns / 1ps

// forms the high level v2 and low level v1 from lightness and saturation
module hsl_levels #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_in,
  input  logic [FRAC_BITS:0]   lq_in,
  input  logic [FRAC_BITS:0]   sq_in,
  input  hsl_pkg::hsl_side_t   side_in,
  output logic                 valid_out,
  output logic [FRAC_BITS:0]   v1_out,
  output logic [FRAC_BITS:0]   v2_out,
  output hsl_pkg::hsl_side_t   side_out
);

  localparam int unsigned QW = FRAC_BITS + 1;
  localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;

  logic               valid3_r, valid4_r, valid5_r;
  logic [2*QW-1:0]    prod3_r;
  logic [QW-1:0]      lq3_r, sq3_r, lq4_r, v2_4_r;
  logic [QW-1:0]      v1_r, v2_r;
  hsl_pkg::hsl_side_t side3_r, side4_r, side5_r;

  logic [2*QW-1:0]    prod_rnd;
  logic [QW-1:0]      sl;
  logic [QW:0]        v2_raw;
  logic [QW-1:0]      v2_nxt, v1_nxt;
  logic [QW:0]        two_lq;

  assign prod_rnd = prod3_r + ((2*QW)'(1) << (FRAC_BITS - 1));
  assign sl       = prod_rnd[FRAC_BITS +: QW];

  always_comb begin
    // dark half: L*(1+S); light half: L+S-L*S
    if (!side3_r.lightness[7]) begin
      v2_raw = {1'b0, lq3_r} + {1'b0, sl};
    end else begin
      v2_raw = {1'b0, lq3_r} + {1'b0, sq3_r} - {1'b0, sl};
    end
    if (v2_raw > {1'b0, ONE}) begin
      v2_nxt = ONE;
    end else begin
      v2_nxt = v2_raw[QW-1:0];
    end
  end

  always_comb begin
    logic [QW:0] diff;
    two_lq = {lq4_r, 1'b0};
    diff   = two_lq - {1'b0, v2_4_r};
    if (two_lq >= {1'b0, v2_4_r}) begin
      if (diff > {1'b0, v2_4_r}) begin
        v1_nxt = v2_4_r;
      end else begin
        v1_nxt = diff[QW-1:0];
      end
    end else begin
      v1_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid3_r <= 1'b0;
      valid4_r <= 1'b0;
      valid5_r <= 1'b0;
    end else if (en) begin
      valid3_r <= valid_in;
      valid4_r <= valid3_r;
      valid5_r <= valid4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod3_r <= (2*QW)'(lq_in) * (2*QW)'(sq_in);
      lq3_r   <= lq_in;
      sq3_r   <= sq_in;
      side3_r <= side_in;
      lq4_r   <= lq3_r;
      v2_4_r  <= v2_nxt;
      side4_r <= side3_r;
      v1_r    <= v1_nxt;
      v2_r    <= v2_4_r;
      side5_r <= side4_r;
    end
  end

  assign valid_out = valid5_r;
  assign v1_out    = v1_r;
  assign v2_out    = v2_r;
  assign side_out  = side5_r;

  a_v1_below_v2: assert property (@(posedge clk) disable iff (!rst_n)
    valid5_r |-> (v1_r <= v2_r))
    else $error("low level above high level");

  a_v2_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    valid4_r |-> (v2_4_r <= ONE))
    else $error("high level above full scale");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && valid5_r) |=> (valid5_r && $stable(v1_r) && $stable(v2_r)))
    else $error("level stage changed while stalled");

endmodule

// ----- sv/hsl_ramp.sv -----
`timescale 1ns / 1ps

// evaluates the hue ramp for the three channels and scales to 8 bits; zero saturation passes lightness
module hsl_ramp #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_in,
  input  logic [FRAC_BITS:0]   v1_in,
  input  logic [FRAC_BITS:0]   v2_in,
  input  hsl_pkg::hsl_side_t   side_in,
  output logic                 valid_out,
  output hsl_pkg::rgb_out_t    data_out
);

  localparam int unsigned QW = FRAC_BITS + 1;
  localparam int unsigned TW = QW + 7;
  localparam int unsigned NW = TW + 9;
  localparam int unsigned SW = hsl_pkg::SCALED_W;
  localparam int unsigned MW = SW + hsl_pkg::DIV60_MUL_W;
  localparam logic [NW-1:0] HALF_DEN = NW'(hsl_pkg::RAMP_SPAN / 2) << FRAC_BITS;

  logic               valid6_r, valid7_r, valid8_r, valid9_r;
  logic [TW-1:0]      base6_r;
  logic [TW-1:0]      dk6_r     [hsl_pkg::NUM_CHAN];
  logic [SW-1:0]      scaled7_r [hsl_pkg::NUM_CHAN];
  logic [SW-1:0]      scaled8_r [hsl_pkg::NUM_CHAN];
  logic [MW-1:0]      m8_r      [hsl_pkg::NUM_CHAN];
  logic [7:0]         chan9_r   [hsl_pkg::NUM_CHAN];
  hsl_pkg::hsl_side_t side6_r, side7_r, side8_r;

  logic [QW-1:0]      span;
  logic [SW-1:0]      scaled_nxt [hsl_pkg::NUM_CHAN];
  logic [7:0]         chan_nxt   [hsl_pkg::NUM_CHAN];

  assign span = v2_in - v1_in;

  // 255 * (60*v1 + (v2-v1)*k), rounded, then divided by 2^F
  always_comb begin
    for (int c = 0; c < hsl_pkg::NUM_CHAN; c++) begin
      logic [TW-1:0] t;
      logic [NW-1:0] num;
      t   = base6_r + dk6_r[c];
      num = NW'({t, 8'b0}) - NW'(t) + HALF_DEN;
      scaled_nxt[c] = num[FRAC_BITS +: SW];
    end
  end

  always_comb begin
    for (int c = 0; c < hsl_pkg::NUM_CHAN; c++) begin
      logic [8:0]    qe;
      logic [SW-1:0] qm, rem;
      qe  = m8_r[c][hsl_pkg::DIV60_SHIFT +: 9];
      qm  = SW'({qe, 6'b0} - {4'b0, qe, 2'b0});
      rem = scaled8_r[c] - qm;
      if (rem >= SW'(hsl_pkg::RAMP_SPAN)) begin
        qe = qe + 9'd1;
      end
      if (side8_r.zero_sat) begin
        chan_nxt[c] = side8_r.lightness;
      end else if (qe > 9'(hsl_pkg::CHAN_MAX)) begin
        chan_nxt[c] = 8'(hsl_pkg::CHAN_MAX);
      end else begin
        chan_nxt[c] = qe[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid6_r <= 1'b0;
      valid7_r <= 1'b0;
      valid8_r <= 1'b0;
      valid9_r <= 1'b0;
    end else if (en) begin
      valid6_r <= valid_in;
      valid7_r <= valid6_r;
      valid8_r <= valid7_r;
      valid9_r <= valid8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base6_r <= TW'({v1_in, 6'b0}) - TW'({v1_in, 2'b0});
      side6_r <= side_in;
      side7_r <= side6_r;
      side8_r <= side7_r;
      for (int c = 0; c < hsl_pkg::NUM_CHAN; c++) begin
        dk6_r[c]     <= TW'(span) * TW'(side_in.k[c]);
        scaled7_r[c] <= scaled_nxt[c];
        scaled8_r[c] <= scaled7_r[c];
        m8_r[c]      <= MW'(scaled7_r[c]) * MW'(hsl_pkg::DIV60_MUL);
        chan9_r[c]   <= chan_nxt[c];
      end
    end
  end

  assign valid_out      = valid9_r;
  assign data_out.red   = chan9_r[hsl_pkg::CHAN_RED];
  assign data_out.green = chan9_r[hsl_pkg::CHAN_GREEN];
  assign data_out.blue  = chan9_r[hsl_pkg::CHAN_BLUE];

endmodule

// ----- sv/hsl_to_rgb_converter.sv -----
`timescale 1ns / 1ps

// channel  direction  ports                        payload
// input    in         in_valid in_ready in_data    hsl_pkg::hsl_in_t (hue, sat, light)
// result   out        out_valid out_ready out_data hsl_pkg::rgb_out_t (red, green, blue)
//
// nine register stages; one pixel accepted every clock unless a stall on out_ready holds the pipe
// the pace is set by the pipeline clock; the deepest stage holds the
// reciprocal multiply of the divide by 255 (F+8 by F+3 bits)
// rst_n clears every stage valid bit; data registers are not reset
// a stall on out_ready freezes all stages together, so nothing is lost
module hsl_to_rgb_converter #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hsl_pkg::hsl_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hsl_pkg::rgb_out_t  out_data
);

  logic                 en;
  logic                 norm_valid, lev_valid;
  logic [FRAC_BITS:0]   lq, sq, v1, v2;
  hsl_pkg::hsl_side_t   norm_side, lev_side;

  // the whole pipe moves unless a finished transaction waits at the output
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  hsl_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (in_valid),
    .data_in   (in_data),
    .valid_out (norm_valid),
    .lq_out    (lq),
    .sq_out    (sq),
    .side_out  (norm_side)
  );

  hsl_levels #(.FRAC_BITS(FRAC_BITS)) u_levels (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (norm_valid),
    .lq_in     (lq),
    .sq_in     (sq),
    .side_in   (norm_side),
    .valid_out (lev_valid),
    .v1_out    (v1),
    .v2_out    (v2),
    .side_out  (lev_side)
  );

  hsl_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (lev_valid),
    .v1_in     (v1),
    .v2_in     (v2),
    .side_in   (lev_side),
    .valid_out (out_valid),
    .data_out  (out_data)
  );

endmodule

// ----- tb/sv/hsl_rgb_checker.sv -----
`timescale 1ns / 1ps

module hsl_rgb_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  hsl_pkg::hsl_in_t   in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  hsl_pkg::rgb_out_t  out_data,
  output int                 errors,
  output int                 pending,
  output int                 checked
);

  typedef struct packed {
    hsl_pkg::hsl_in_t  px;
    hsl_pkg::rgb_out_t rgb;
  } pixel_pair_t;

  pixel_pair_t rgb_q[$];
  pixel_pair_t head;
  int          err_count = 0;
  int          pending_cnt = 0;
  int          checked_cnt = 0;

  assign errors  = err_count;
  assign pending = pending_cnt;
  assign checked = checked_cnt;

  // channel level at a whole-degree ramp position, rounded half up
  function automatic logic [7:0] ramp_level(input longint unsigned lo,
                                            input longint unsigned hi,
                                            input int unsigned deg);
    longint unsigned k;
    longint unsigned num;
    longint unsigned den;
    longint unsigned r;
    if (deg < hsl_pkg::RAMP_RISE_END) begin
      k = deg;
    end else if (deg < hsl_pkg::RAMP_FALL_START) begin
      k = hsl_pkg::RAMP_SPAN;
    end else if (deg < hsl_pkg::RAMP_FALL_END) begin
      k = hsl_pkg::RAMP_FALL_END - deg;
    end else begin
      k = 0;
    end
    num = hsl_pkg::CHAN_MAX * (lo * hsl_pkg::RAMP_SPAN + (hi - lo) * k);
    den = longint'(hsl_pkg::RAMP_SPAN) << FRAC_BITS;
    r = (num + den / 2) / den;
    if (r > hsl_pkg::CHAN_MAX) begin
      r = hsl_pkg::CHAN_MAX;
    end
    return r[7:0];
  endfunction

  function automatic hsl_pkg::rgb_out_t convert_hsl(input hsl_pkg::hsl_in_t px);
    longint unsigned   one;
    longint unsigned   lq;
    longint unsigned   sq;
    longint unsigned   sl;
    longint unsigned   lo;
    longint unsigned   hi;
    int unsigned       hue;
    int unsigned       deg_r;
    int unsigned       deg_b;
    hsl_pkg::rgb_out_t rgb;
    one = longint'(1) << FRAC_BITS;
    hue = px.hue_degrees;
    if (hue >= hsl_pkg::HUE_WRAP) begin
      hue = hue - hsl_pkg::HUE_WRAP;
    end
    if (px.saturation == 8'd0) begin
      rgb.red   = px.lightness;
      rgb.green = px.lightness;
      rgb.blue  = px.lightness;
      return rgb;
    end
    lq = (longint'(px.lightness) * one + 127) / hsl_pkg::CHAN_MAX;
    sq = (longint'(px.saturation) * one + 127) / hsl_pkg::CHAN_MAX;
    sl = (lq * sq + one / 2) >> FRAC_BITS;
    // upper level: l*(1+s) below half scale, l+s-l*s above
    if (px.lightness <= 8'd127) begin
      hi = lq + sl;
    end else begin
      hi = lq + sq - sl;
    end
    if (hi > one) begin
      hi = one;
    end
    if (2 * lq >= hi) begin
      lo = 2 * lq - hi;
    end else begin
      lo = 0;
    end
    if (lo > hi) begin
      lo = hi;
    end
    deg_r = hue + hsl_pkg::HUE_THIRD;
    if (deg_r >= hsl_pkg::HUE_WRAP) begin
      deg_r = deg_r - hsl_pkg::HUE_WRAP;
    end
    deg_b = hue + hsl_pkg::HUE_TWO_THIRDS;
    if (deg_b >= hsl_pkg::HUE_WRAP) begin
      deg_b = deg_b - hsl_pkg::HUE_WRAP;
    end
    rgb.red   = ramp_level(lo, hi, deg_r);
    rgb.green = ramp_level(lo, hi, hue);
    rgb.blue  = ramp_level(lo, hi, deg_b);
    return rgb;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_chan(input string name, input logic [7:0] got, input logic [7:0] want,
                            input hsl_pkg::hsl_in_t px);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d want %0d (hue %0d sat %0d light %0d)", name, got,
                                want, px.hue_degrees, px.saturation, px.lightness));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        rgb_q.push_back('{px: in_data, rgb: convert_hsl(in_data)});
      end
      if (out_valid && out_ready) begin
        if (rgb_q.size() == 0) begin
          report_mismatch($sformatf("unexpected output transaction %h", out_data));
        end else begin
          head = rgb_q.pop_front();
          check_chan("red", out_data.red, head.rgb.red, head.px);
          check_chan("green", out_data.green, head.rgb.green, head.px);
          check_chan("blue", out_data.blue, head.rgb.blue, head.px);
          checked_cnt <= checked_cnt + 1;
        end
      end
      pending_cnt <= rgb_q.size();
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int NUM_RANDOM = 400;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  hsl_pkg::hsl_in_t   in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  hsl_pkg::rgb_out_t  out_data;
  int                 errors;
  int                 pending;
  int                 checked;
  int                 rx_cycle = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hsl_to_rgb_converter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  hsl_rgb_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  // receiver: a long hold-off early on to back up the pipeline, then a
  // stretch that is always ready, random stalls elsewhere
  always @(posedge clk) begin
    if (rst_n) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle >= 40 && rx_cycle < 90) begin
        out_ready <= 1'b0;
      end else if (rx_cycle >= 200 && rx_cycle < 400) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 14);
      end
    end
  end

  task automatic send_pixel(input int hue, input int sat, input int light, input bit may_idle);
    hsl_pkg::hsl_in_t px;
    px.hue_degrees = 9'(hue);
    px.saturation  = 8'(sat);
    px.lightness   = 8'(light);
    while (may_idle && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    int hue;
    int sat;
    int light;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ramp breakpoints on both sides, at full saturation mid lightness
    send_pixel(0, 255, 128, 1'b1);
    send_pixel(59, 255, 128, 1'b1);
    send_pixel(60, 255, 128, 1'b1);
    send_pixel(179, 255, 128, 1'b1);
    send_pixel(180, 255, 128, 1'b1);
    send_pixel(239, 255, 128, 1'b1);
    send_pixel(240, 255, 128, 1'b1);
    send_pixel(359, 255, 128, 1'b1);
    // hue wrap at and above 360
    send_pixel(360, 255, 128, 1'b1);
    send_pixel(511, 255, 128, 1'b1);
    send_pixel(480, 200, 100, 1'b1);
    // gray: output equals lightness
    send_pixel(100, 0, 0, 1'b1);
    send_pixel(200, 0, 255, 1'b1);
    send_pixel(511, 0, 77, 1'b1);
    // lightness extremes and the half-scale branch
    send_pixel(0, 255, 0, 1'b1);
    send_pixel(0, 255, 255, 1'b1);
    send_pixel(120, 255, 127, 1'b1);
    send_pixel(30, 1, 127, 1'b1);
    send_pixel(30, 1, 128, 1'b1);
    send_pixel(90, 128, 64, 1'b1);
    send_pixel(200, 254, 200, 1'b1);
    send_pixel(45, 255, 1, 1'b1);
    send_pixel(315, 255, 254, 1'b1);
    send_pixel(0, 1, 1, 1'b1);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      hue   = $urandom_range(511);
      sat   = $urandom_range(255);
      light = $urandom_range(255);
      case ($urandom_range(9))
        0: sat = 0;
        1: hue = $urandom_range(511, 360);
        2: light = $urandom_range(1) ? 255 : 0;
        3: light = $urandom_range(129, 126);
        4: sat = $urandom_range(1) ? 255 : 1;
        default: ;
      endcase
      // back-to-back stretch with no sender gaps
      send_pixel(hue, sat, light, !(i >= 150 && i < 250));
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("checked %0d pixels: ramp breakpoints, hue wrap, gray, lightness extremes, random",
             checked);
    $display("both channels idled at random; a 50-cycle output hold-off filled the pipeline");
    if (errors == 0) begin
      $display("PASS hsl_to_rgb_converter");
    end else begin
      $display("FAIL hsl_to_rgb_converter");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL hsl_to_rgb_converter");
    $finish;
  end

endmodule

// ----- hsl_to_rgb_converter.f -----
sv/hsl_pkg.sv
sv/hsl_norm.sv
sv/hsl_levels.sv
sv/hsl_ramp.sv
sv/hsl_to_rgb_converter.sv
tb/sv/hsl_rgb_checker.sv
tb/sv/tb.sv
